@@ rtl/pec_pkg.sv @@
// shared constants and types for the peak event count block
`timescale 1ns / 1ps

package pec_pkg;

  localparam int unsigned WINDOW_DEPTH = 1024;
  localparam int unsigned PTR_W        = $clog2(WINDOW_DEPTH);
  localparam int unsigned CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned NUM_W        = 32;
  localparam int unsigned BCNT_W       = 11;

  localparam logic [TIME_W-1:0] SPAN_RESET = TIME_W'(60);

  // operands of the shared subtract and compare unit
  typedef struct packed {
    logic [TIME_W-1:0] minuend;
    logic [TIME_W-1:0] subtrahend;
    logic [TIME_W-1:0] limit;
  } cmp_req_t;

endpackage

@@ rtl/pec_cfg_if.sv @@
// configuration write channel carrying the window span
`timescale 1ns / 1ps

interface pec_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pec_pkg::TIME_W-1:0]  window_span;

  modport source (output valid, output window_span, input ready);
  modport sink   (input valid, input window_span, output ready);
endinterface

@@ rtl/pec_evt_if.sv @@
// input channel carrying one event timestamp per item
`timescale 1ns / 1ps

interface pec_evt_if;
  logic                        valid;
  logic                        ready;
  logic [pec_pkg::TIME_W-1:0]  event_time;

  modport source (output valid, output event_time, input ready);
  modport sink   (input valid, input event_time, output ready);
endinterface

@@ rtl/pec_res_if.sv @@
// result channel carrying the best window so far
`timescale 1ns / 1ps

interface pec_res_if;
  logic                        valid;
  logic                        ready;
  logic [pec_pkg::BCNT_W-1:0]  best_count;
  logic [pec_pkg::TIME_W-1:0]  best_first_time;
  logic [pec_pkg::TIME_W-1:0]  best_last_time;
  logic [pec_pkg::NUM_W-1:0]   best_start_number;
  logic [pec_pkg::NUM_W-1:0]   best_end_number;
  logic                        window_overflow;

  modport source (output valid, output best_count, output best_first_time,
                  output best_last_time, output best_start_number,
                  output best_end_number, output window_overflow, input ready);
  modport sink   (input valid, input best_count, input best_first_time,
                  input best_last_time, input best_start_number,
                  input best_end_number, input window_overflow, output ready);
endinterface

@@ rtl/peak_event_count_time_window_top.sv @@
// top level of the peak event count sequencer
`timescale 1ns / 1ps

// peak event count within a sliding time window
// cfg_i: write the window span (seconds) while the block is idle; always ready
// evt_i: one event timestamp per item, expected non-decreasing
// res_o: one result per item, the best window seen so far plus an overflow flag
// held timestamps sit in a ring ram; a small sequencer drives one shared
// subtract and compare unit, first to drop events older than the span, one
// ram read and one compare per dropped event, then to test the new count
// against the best count
// an item runs from acceptance through a ram read, one compare per held
// event tested for age (none when no event is held), the store, a read of
// the oldest held entry and the count compare; evt_i is not ready
// meanwhile and is ready again in the cycle the result appears
// the result waits in an output register, so the next item is taken while
// an earlier result is still stalled; a second finished result waits in
// the sequencer until res_o is taken
// reset clears the counters, the best window and the output register and
// sets the span to 60; the ring needs no clearing since only held entries
// are ever read
module peak_event_count_time_window_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  pec_cfg_if.sink        cfg_i,
  pec_evt_if.sink        evt_i,
  pec_res_if.source      res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP_RD,
    ST_DROP_CMP,
    ST_STORE,
    ST_FIRST_RD,
    ST_FIRST,
    ST_DONE
  } state_e;

  localparam int unsigned PW = pec_pkg::PTR_W;
  localparam int unsigned CW = pec_pkg::CNT_W;
  localparam int unsigned TW = pec_pkg::TIME_W;
  localparam int unsigned NW = pec_pkg::NUM_W;

  state_e            state_q;
  logic [TW-1:0]     span_q;
  logic [TW-1:0]     t_q;
  logic [PW-1:0]     wr_ptr_q;
  logic [PW-1:0]     rd_ptr_q;
  logic [CW-1:0]     held_q;
  logic [NW-1:0]     newest_q;
  logic [NW-1:0]     oldest_q;
  logic [CW-1:0]     best_cnt_q;
  logic [TW-1:0]     best_first_q;
  logic [TW-1:0]     best_last_q;
  logic [NW-1:0]     best_start_q;
  logic [NW-1:0]     best_end_q;
  logic [TW-1:0]     first_q;
  logic              gt_q;
  logic              ovf_q;
  logic              res_valid_q;

  logic [PW-1:0]     rd_ptr_inc;
  logic [PW-1:0]     wr_ptr_inc;
  logic              ram_re;
  logic [PW-1:0]     ram_raddr;
  logic [TW-1:0]     ram_rdata;
  pec_pkg::cmp_req_t cmp_req;
  logic              cmp_gt;
  logic              out_free;

  logic [CW-1:0]     nb_cnt;
  logic [TW-1:0]     nb_first;
  logic [TW-1:0]     nb_last;
  logic [NW-1:0]     nb_start;
  logic [NW-1:0]     nb_end;

  assign rd_ptr_inc = (rd_ptr_q == PW'(pec_pkg::WINDOW_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
  assign wr_ptr_inc = (wr_ptr_q == PW'(pec_pkg::WINDOW_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;

  // on a drop the next oldest entry is fetched at once
  assign ram_raddr = (state_q == ST_DROP_CMP) ? rd_ptr_inc : rd_ptr_q;
  assign ram_re    = ((state_q == ST_DROP_RD) && (held_q != '0))
                   || ((state_q == ST_DROP_CMP) && cmp_gt && (held_q != CW'(1)))
                   || (state_q == ST_FIRST_RD);

  always_comb begin
    if (state_q == ST_FIRST) begin
      cmp_req.minuend    = TW'(held_q);
      cmp_req.subtrahend = '0;
      cmp_req.limit      = TW'(best_cnt_q);
    end else begin
      cmp_req.minuend    = t_q;
      cmp_req.subtrahend = ram_rdata;
      cmp_req.limit      = span_q;
    end
  end

  pec_ram #(
    .WIDTH (TW),
    .DEPTH (pec_pkg::WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_STORE),
    .waddr_i (wr_ptr_q),
    .wdata_i (t_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pec_cmp u_cmp (
    .req_i (cmp_req),
    .gt_o  (cmp_gt)
  );

  assign nb_cnt   = gt_q ? held_q           : best_cnt_q;
  assign nb_first = gt_q ? first_q          : best_first_q;
  assign nb_last  = gt_q ? t_q              : best_last_q;
  assign nb_start = gt_q ? oldest_q + 1'b1  : best_start_q;
  assign nb_end   = gt_q ? newest_q         : best_end_q;

  assign out_free = !res_valid_q || res_o.ready;

  assign evt_i.ready = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign res_o.valid = res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q                 <= ST_IDLE;
      span_q                  <= pec_pkg::SPAN_RESET;
      t_q                     <= '0;
      wr_ptr_q                <= '0;
      rd_ptr_q                <= '0;
      held_q                  <= '0;
      newest_q                <= '0;
      oldest_q                <= '0;
      best_cnt_q              <= '0;
      best_first_q            <= '0;
      best_last_q             <= '0;
      best_start_q            <= '0;
      best_end_q              <= '0;
      first_q                 <= '0;
      gt_q                    <= 1'b0;
      ovf_q                   <= 1'b0;
      res_valid_q             <= 1'b0;
      res_o.best_count        <= '0;
      res_o.best_first_time   <= '0;
      res_o.best_last_time    <= '0;
      res_o.best_start_number <= '0;
      res_o.best_end_number   <= '0;
      res_o.window_overflow   <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        span_q <= cfg_i.window_span;
      end
      if ((state_q == ST_DONE) && out_free) begin
        res_valid_q <= 1'b1;
      end else if (res_valid_q && res_o.ready) begin
        res_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (evt_i.valid) begin
            t_q     <= evt_i.event_time;
            ovf_q   <= 1'b0;
            state_q <= ST_DROP_RD;
          end
        end
        ST_DROP_RD: begin
          state_q <= (held_q != '0) ? ST_DROP_CMP : ST_STORE;
        end
        ST_DROP_CMP: begin
          if (cmp_gt) begin
            rd_ptr_q <= rd_ptr_inc;
            held_q   <= held_q - 1'b1;
            oldest_q <= oldest_q + 1'b1;
            state_q  <= (held_q == CW'(1)) ? ST_STORE : ST_DROP_CMP;
          end else begin
            state_q <= ST_STORE;
          end
        end
        ST_STORE: begin
          wr_ptr_q <= wr_ptr_inc;
          newest_q <= newest_q + 1'b1;
          // full ring: oldest is forced out, count stays at the depth
          if (held_q == CW'(pec_pkg::WINDOW_DEPTH)) begin
            rd_ptr_q <= rd_ptr_inc;
            oldest_q <= oldest_q + 1'b1;
            ovf_q    <= 1'b1;
          end else begin
            held_q <= held_q + 1'b1;
          end
          state_q <= ST_FIRST_RD;
        end
        ST_FIRST_RD: begin
          state_q <= ST_FIRST;
        end
        ST_FIRST: begin
          first_q <= ram_rdata;
          gt_q    <= cmp_gt;
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            best_cnt_q              <= nb_cnt;
            best_first_q            <= nb_first;
            best_last_q             <= nb_last;
            best_start_q            <= nb_start;
            best_end_q              <= nb_end;
            res_o.best_count        <= pec_pkg::BCNT_W'(nb_cnt);
            res_o.best_first_time   <= nb_first;
            res_o.best_last_time    <= nb_last;
            res_o.best_start_number <= nb_start;
            res_o.best_end_number   <= nb_end;
            res_o.window_overflow   <= ovf_q;
            state_q                 <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/pec_ram.sv @@
// generic single write port ram with registered read
`timescale 1ns / 1ps

module pec_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/pec_cmp.sv @@
// shared subtract and compare unit: true when minuend - subtrahend > limit without borrow
`timescale 1ns / 1ps

module pec_cmp (
  input  pec_pkg::cmp_req_t req_i,
  output logic              gt_o
);

  logic [pec_pkg::TIME_W:0] diff;

  assign diff = {1'b0, req_i.minuend} - {1'b0, req_i.subtrahend};
  assign gt_o = !diff[pec_pkg::TIME_W] && (diff[pec_pkg::TIME_W-1:0] > req_i.limit);

endmodule

@@ rtl/pec_checker.sv @@
// port level checks for the peak event count block and their bind
`timescale 1ns / 1ps

module pec_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       evt_valid_i,
  input  logic                       evt_ready_i,
  input  logic                       res_valid_i,
  input  logic                       res_ready_i,
  input  logic [pec_pkg::BCNT_W-1:0] best_count_i,
  input  logic [pec_pkg::NUM_W-1:0]  best_start_number_i,
  input  logic [pec_pkg::NUM_W-1:0]  best_end_number_i
);

  // one item at a time: no second item right after one is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && evt_ready_i |=> !evt_ready_i)
    else $error("item taken while previous item still in work");

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(best_count_i)
      && $stable(best_start_number_i) && $stable(best_end_number_i))
    else $error("stalled item changed");

  // event numbers of the best window agree with its count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (best_count_i != '0) |->
      (best_end_number_i - best_start_number_i + 1'b1)
        == pec_pkg::NUM_W'(best_count_i))
    else $error("best window numbers disagree with count");

  // a result only ever shows a non-empty window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i |-> best_count_i != '0)
    else $error("empty best window reported");

endmodule

bind peak_event_count_time_window_top pec_checker u_pec_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .evt_valid_i         (evt_i.valid),
  .evt_ready_i         (evt_i.ready),
  .res_valid_i         (res_o.valid),
  .res_ready_i         (res_o.ready),
  .best_count_i        (res_o.best_count),
  .best_start_number_i (res_o.best_start_number),
  .best_end_number_i   (res_o.best_end_number)
);

@@ tb/peak_event_count_time_window_checker.sv @@
// checker that predicts the best window per item and compares each result item
`timescale 1ns / 1ps

module peak_event_count_time_window_checker (
  input  logic clk_i,
  input  logic rst_ni,
  pec_cfg_if   cfg_i,
  pec_evt_if   evt_i,
  pec_res_if   res_i,
  output int   fails_o,
  output int   expected_left_o
);

  typedef struct packed {
    logic [pec_pkg::BCNT_W-1:0] count;
    logic [pec_pkg::TIME_W-1:0] first_time;
    logic [pec_pkg::TIME_W-1:0] last_time;
    logic [pec_pkg::NUM_W-1:0]  start_num;
    logic [pec_pkg::NUM_W-1:0]  end_num;
    logic                       overflow;
  } window_report_t;

  logic [pec_pkg::TIME_W-1:0] span;
  logic [pec_pkg::TIME_W-1:0] stamps [pec_pkg::WINDOW_DEPTH];
  logic [pec_pkg::NUM_W-1:0]  taken_num;
  logic [pec_pkg::NUM_W-1:0]  dropped_num;
  logic [31:0]                best_cnt;
  logic [pec_pkg::TIME_W-1:0] best_first;
  logic [pec_pkg::TIME_W-1:0] best_last;
  logic [pec_pkg::NUM_W-1:0]  best_start;
  logic [pec_pkg::NUM_W-1:0]  best_end;
  int unsigned                slot;
  int                         fail_total;

  window_report_t reports_due [$];

  function automatic int unsigned oldest_idx();
    logic [pec_pkg::NUM_W-1:0] held;
    held = taken_num - dropped_num;
    return (slot + pec_pkg::WINDOW_DEPTH - (held % pec_pkg::WINDOW_DEPTH))
           % pec_pkg::WINDOW_DEPTH;
  endfunction

  function automatic window_report_t take_event(input logic [pec_pkg::TIME_W-1:0] t);
    window_report_t             r;
    logic [pec_pkg::TIME_W-1:0] old;
    logic [pec_pkg::NUM_W-1:0]  held;
    bit                         dropping;
    r.overflow = 1'b0;
    dropping   = 1'b1;
    while (dropping && (taken_num - dropped_num) != 0) begin
      old = stamps[oldest_idx()];
      if (t > old && (t - old) > span) dropped_num++;
      else dropping = 1'b0;
    end
    // full ring: the oldest goes even though it is inside the span
    if ((taken_num - dropped_num) >= pec_pkg::WINDOW_DEPTH) begin
      dropped_num = taken_num - pec_pkg::NUM_W'(pec_pkg::WINDOW_DEPTH - 1);
      r.overflow  = 1'b1;
    end
    stamps[slot] = t;
    slot         = (slot + 1) % pec_pkg::WINDOW_DEPTH;
    taken_num++;
    held = taken_num - dropped_num;
    if (held > best_cnt) begin
      best_cnt   = held;
      best_first = stamps[oldest_idx()];
      best_last  = t;
      best_start = dropped_num + 1;
      best_end   = taken_num;
    end
    r.count      = best_cnt[pec_pkg::BCNT_W-1:0];
    r.first_time = best_first;
    r.last_time  = best_last;
    r.start_num  = best_start;
    r.end_num    = best_end;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0d, got %0d", name, exp, act);
      fail_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    window_report_t due;
    if (!rst_ni) begin
      span        = pec_pkg::SPAN_RESET;
      taken_num   = '0;
      dropped_num = '0;
      best_cnt    = '0;
      best_first  = '0;
      best_last   = '0;
      best_start  = '0;
      best_end    = '0;
      slot        = 0;
      fail_total  = 0;
      reports_due.delete();
      expected_left_o <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) span = cfg_i.window_span;
      if (evt_i.valid && evt_i.ready) reports_due.push_back(take_event(evt_i.event_time));
      if (res_i.valid && res_i.ready) begin
        if (reports_due.size() == 0) begin
          $error("result item with no item pending");
          fail_total++;
        end else begin
          due = reports_due.pop_front();
          check_field("best_count", 32'(due.count), 32'(res_i.best_count));
          check_field("best_first_time", due.first_time, res_i.best_first_time);
          check_field("best_last_time", due.last_time, res_i.best_last_time);
          check_field("best_start_number", due.start_num, res_i.best_start_number);
          check_field("best_end_number", due.end_num, res_i.best_end_number);
          check_field("window_overflow", 32'(due.overflow), 32'(res_i.window_overflow));
        end
      end
      expected_left_o <= reports_due.size();
    end
    fails_o <= fail_total;
  end

endmodule

@@ tb/peak_event_count_time_window_top_tb.sv @@
// testbench top: stimulus, handshake idling and the final verdict
`timescale 1ns / 1ps

module peak_event_count_time_window_top_tb;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic        clk_i;
  logic        rst_ni;
  bit          calm;
  logic [31:0] now;
  int          fails;
  int          expected_left;
  int unsigned cycle_count;

  pec_cfg_if cfg ();
  pec_evt_if evt ();
  pec_res_if res ();

  peak_event_count_time_window_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .evt_i  (evt),
    .res_o  (res)
  );

  peak_event_count_time_window_checker checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .evt_i           (evt),
    .res_i           (res),
    .fails_o         (fails),
    .expected_left_o (expected_left)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  initial cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    int on_len;
    int off_len;
    res.ready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      res.ready <= 1'b1;
      on_len = calm ? 50 : $urandom_range(1, 12);
      repeat (on_len) @(posedge clk_i);
      off_len = pick_gap();
      if (off_len > 0) begin
        res.ready <= 1'b0;
        repeat (off_len) @(posedge clk_i);
      end
    end
  end

  task automatic send_event(input logic [31:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      evt.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    evt.valid      <= 1'b1;
    evt.event_time <= t;
    @(posedge clk_i);
    while (!evt.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    @(posedge clk_i);
    while (expected_left != 0) @(posedge clk_i);
  endtask

  task automatic write_span(input logic [31:0] v);
    evt.valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk_i);
    cfg.valid       <= 1'b1;
    cfg.window_span <= v;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    cfg.valid <= 1'b0;
  endtask

  task automatic run_random(input int n, input int unsigned max_inc, input bit wide);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      // a few items jump anywhere or step back, the rest climb
      if (r < 6) now = $urandom;
      else if (r < 12) now = now - $urandom_range(0, 50);
      else if (wide) now = now + ($urandom >> $urandom_range(4, 31));
      else now = now + $urandom_range(0, max_inc);
      send_event(now);
    end
  endtask

  initial begin
    cfg.valid       = 1'b0;
    cfg.window_span = '0;
    evt.valid       = 1'b0;
    evt.event_time  = '0;
    rst_ni          = 1'b0;
    calm            = 1'b0;
    now             = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // span left at its reset value
    send_event(32'd0);
    send_event(32'd0);
    send_event(32'd30);
    send_event(32'd60);
    send_event(32'd61);
    send_event(32'd200);
    send_event(32'd150);
    send_event(32'd260);
    send_event(32'd261);
    send_event(32'hFFFF_FFF0);
    send_event(32'hFFFF_FFFF);
    send_event(32'd0);

    write_span(32'd0);
    send_event(32'd5);
    send_event(32'd5);
    send_event(32'd5);
    send_event(32'd6);
    send_event(32'd6);

    write_span(32'hFFFF_FFFF);
    send_event(32'd0);
    send_event(32'hFFFF_FFFF);
    send_event(32'd7);

    write_span(32'd60);
    now = $urandom_range(0, 1000);
    run_random(130, 30, 1'b0);

    write_span($urandom_range(1, 20));
    run_random(130, 8, 1'b0);

    write_span(32'd0);
    calm = 1'b1;
    run_random(80, 1, 1'b0);
    calm = 1'b0;

    write_span($urandom);
    now = $urandom;
    run_random(130, 0, 1'b1);

    // wide span so nothing leaves the window
    write_span(32'hFFFF_FFFF);
    now = $urandom;
    run_random(80, 3, 1'b0);
    calm = 1'b1;
    run_random(80, 3, 1'b0);
    calm = 1'b0;

    evt.valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);
    if (fails == 0 && expected_left == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/pec_pkg.sv
rtl/pec_cfg_if.sv
rtl/pec_evt_if.sv
rtl/pec_res_if.sv
rtl/pec_ram.sv
rtl/pec_cmp.sv
rtl/peak_event_count_time_window_top.sv
rtl/pec_checker.sv
tb/peak_event_count_time_window_checker.sv
tb/peak_event_count_time_window_top_tb.sv
